/* sv/hip_pkg.sv */
package hip_pkg;

    // field widths
    localparam int INDEX_W    = 16;
    localparam int CELL_OUT_W = 8;
    localparam int PIX_W      = 18;
    localparam int ORDER_W    = 4;
    localparam int SIZE_W     = 10;
    localparam int FRAC_W     = 8;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 56;

    // default grid order limit
    localparam int MAX_ORDER_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURVE_ORDER = 2'd0,
        REG_TOTAL_SIZE  = 2'd1
    } cfg_reg_t;

    localparam logic [ORDER_W-1:0] CURVE_ORDER_RST = 4'd2;
    localparam logic [SIZE_W-1:0]  TOTAL_SIZE_RST  = 10'd450;

    // quadrant codes of one curve level
    localparam logic [1:0] QUAD_SWAP = 2'd0;
    localparam logic [1:0] QUAD_UP   = 2'd1;
    localparam logic [1:0] QUAD_DIAG = 2'd2;
    localparam logic [1:0] QUAD_FLIP = 2'd3;

    // valid and last flag traveling with each item
    typedef struct packed {
        logic valid;
        logic last;
    } hip_tag_t;

    // one result transaction
    typedef struct packed {
        logic [PIX_W-1:0]      pixel_y;
        logic [PIX_W-1:0]      pixel_x;
        logic [CELL_OUT_W-1:0] cell_y;
        logic [CELL_OUT_W-1:0] cell_x;
        logic                  last;
    } hip_result_t;

    // base u pattern (0,0) (0,1) (1,1) (1,0)
    function automatic logic base_x(input logic [1:0] q);
        base_x = q[1];
    endfunction

    function automatic logic base_y(input logic [1:0] q);
        base_y = q[1] ^ q[0];
    endfunction

endpackage

/* sv/hip_scale.sv */
module hip_scale #(
    parameter int CW = hip_pkg::MAX_ORDER_DEF,
    parameter int OW = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  hip_pkg::hip_tag_t                 in_tag,
    input  logic [CW-1:0]                     cell_x,
    input  logic [CW-1:0]                     cell_y,
    input  logic [hip_pkg::SIZE_W-1:0]        total_size,
    input  logic [OW-1:0]                     ord,
    output hip_pkg::hip_tag_t                 out_tag,
    output logic [hip_pkg::CELL_OUT_W-1:0]    out_cell_x,
    output logic [hip_pkg::CELL_OUT_W-1:0]    out_cell_y,
    output logic [hip_pkg::PIX_W-1:0]         pixel_x,
    output logic [hip_pkg::PIX_W-1:0]         pixel_y
);

    localparam int PW = CW + 1 + hip_pkg::SIZE_W;
    localparam int SW = PW + hip_pkg::FRAC_W;

    hip_pkg::hip_tag_t tag_a_reg;
    hip_pkg::hip_tag_t tag_b_reg;
    logic [PW-1:0] prod_x_reg;
    logic [PW-1:0] prod_y_reg;
    logic [PW-1:0] prod_x_next;
    logic [PW-1:0] prod_y_next;
    logic [hip_pkg::CELL_OUT_W-1:0] cx_a_reg;
    logic [hip_pkg::CELL_OUT_W-1:0] cy_a_reg;
    logic [hip_pkg::CELL_OUT_W-1:0] cx_b_reg;
    logic [hip_pkg::CELL_OUT_W-1:0] cy_b_reg;
    logic [hip_pkg::PIX_W-1:0] pix_x_reg;
    logic [hip_pkg::PIX_W-1:0] pix_y_reg;
    logic [hip_pkg::PIX_W-1:0] pix_x_next;
    logic [hip_pkg::PIX_W-1:0] pix_y_next;
    logic [SW-1:0] shift_x;
    logic [SW-1:0] shift_y;
    logic [OW:0]   shamt;

    // odd cell position times side length
    always_comb
    begin
        prod_x_next = PW'({cell_x, 1'b1}) * PW'(total_size);
        prod_y_next = PW'({cell_y, 1'b1}) * PW'(total_size);
    end

    // scale to 8 fraction bits and halve per order level
    always_comb
    begin
        shamt      = (OW + 1)'(ord) + (OW + 1)'(1);
        shift_x    = {prod_x_reg, {hip_pkg::FRAC_W{1'b0}}} >> shamt;
        shift_y    = {prod_y_reg, {hip_pkg::FRAC_W{1'b0}}} >> shamt;
        pix_x_next = hip_pkg::PIX_W'(shift_x);
        pix_y_next = hip_pkg::PIX_W'(shift_y);
    end

    // stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            cx_a_reg   <= hip_pkg::CELL_OUT_W'(cell_x);
            cy_a_reg   <= hip_pkg::CELL_OUT_W'(cell_y);
            pix_x_reg  <= pix_x_next;
            pix_y_reg  <= pix_y_next;
            cx_b_reg   <= cx_a_reg;
            cy_b_reg   <= cy_a_reg;
        end
    end

    assign out_tag    = tag_b_reg;
    assign out_cell_x = cx_b_reg;
    assign out_cell_y = cy_b_reg;
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;

endmodule

/* sv/hilbert_index_to_point.sv */
// pipeline: one index stage, MAX_ORDER - 1 curve level stages, two scaling stages, output register
// throughput: one index per cycle while the skid entry is empty; the multiply stage of the pixel scaling sets the clock
// reset: curve_order 2, total_size 450, pipeline and output buffer empty
module hilbert_index_to_point #(
    parameter int MAX_ORDER = hip_pkg::MAX_ORDER_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // curve_index[15:0]
    input  logic [hip_pkg::TDATA_IN_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_x[7:0], cell_y[15:8], pixel_x[33:16], pixel_y[51:34], zero[55:52]
    output logic [hip_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [hip_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [hip_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = MAX_ORDER;
    localparam int IW = (2 * MAX_ORDER > hip_pkg::INDEX_W) ? 2 * MAX_ORDER : hip_pkg::INDEX_W;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int L  = MAX_ORDER - 1;

    logic [hip_pkg::ORDER_W-1:0] curve_order_reg;
    logic [hip_pkg::SIZE_W-1:0]  total_size_reg;
    logic [OW-1:0]               eff_ord;
    logic [IW-1:0]               idx_mask;
    logic [IW-1:0]               idx_in;
    logic                        adv;

    logic                v_reg    [0:MAX_ORDER-1];
    logic                last_reg [0:MAX_ORDER-1];
    logic [IW-1:0]       idx_reg  [0:MAX_ORDER-1];
    logic [CW-1:0]       x_reg    [0:MAX_ORDER-1];
    logic [CW-1:0]       y_reg    [0:MAX_ORDER-1];

    hip_pkg::hip_tag_t           lvl_tag;
    hip_pkg::hip_tag_t           sc_tag;
    logic [hip_pkg::CELL_OUT_W-1:0] sc_cell_x;
    logic [hip_pkg::CELL_OUT_W-1:0] sc_cell_y;
    logic [hip_pkg::PIX_W-1:0]   sc_pixel_x;
    logic [hip_pkg::PIX_W-1:0]   sc_pixel_y;

    logic                  push;
    hip_pkg::hip_result_t  push_data;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hip_pkg::hip_result_t  out_data_reg;
    hip_pkg::hip_result_t  out_data_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    hip_pkg::hip_result_t  skid_data_reg;
    hip_pkg::hip_result_t  skid_data_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg <= hip_pkg::CURVE_ORDER_RST;
            total_size_reg  <= hip_pkg::TOTAL_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                hip_pkg::REG_CURVE_ORDER: curve_order_reg <= cfg_data[hip_pkg::ORDER_W-1:0];
                hip_pkg::REG_TOTAL_SIZE:  total_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // order clamped to the supported range, index mask
    always_comb
    begin
        if (curve_order_reg == '0)
            eff_ord = OW'(1);
        else if (int'(curve_order_reg) > MAX_ORDER)
            eff_ord = OW'(MAX_ORDER);
        else
            eff_ord = OW'(curve_order_reg);
        idx_mask = ~({IW{1'b1}} << {eff_ord, 1'b0});
        idx_in   = IW'(s_tdata) & idx_mask;
    end

    // pipeline moves whenever the output buffer has room
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // index stage: mask, base u point, last flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg[0]  <= idx_in;
            x_reg[0]    <= CW'(hip_pkg::base_x(idx_in[1:0]));
            y_reg[0]    <= CW'(hip_pkg::base_y(idx_in[1:0]));
            last_reg[0] <= (idx_in == idx_mask);
        end
    end

    // one stage per curve level
    for (genvar j = 1; j < MAX_ORDER; j++)
    begin : g_level
        localparam logic [CW-1:0] S    = CW'(1 << j);
        localparam logic [CW-1:0] SM1  = CW'((1 << j) - 1);
        localparam logic [CW-1:0] S2M1 = CW'((1 << (j + 1)) - 1);

        logic [1:0]    q;
        logic [CW-1:0] nx;
        logic [CW-1:0] ny;

        // move the point by its quadrant at this level
        always_comb
        begin
            q  = idx_reg[j-1][2*j +: 2];
            nx = x_reg[j-1];
            ny = y_reg[j-1];
            if (j < int'(eff_ord))
            begin
                unique case (q)
                    hip_pkg::QUAD_SWAP:
                    begin
                        nx = y_reg[j-1];
                        ny = x_reg[j-1];
                    end
                    hip_pkg::QUAD_UP:
                    begin
                        ny = y_reg[j-1] + S;
                    end
                    hip_pkg::QUAD_DIAG:
                    begin
                        nx = x_reg[j-1] + S;
                        ny = y_reg[j-1] + S;
                    end
                    hip_pkg::QUAD_FLIP:
                    begin
                        nx = S2M1 - y_reg[j-1];
                        ny = SM1 - x_reg[j-1];
                    end
                    default: ;
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (adv)
                v_reg[j] <= v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                idx_reg[j]  <= idx_reg[j-1];
                last_reg[j] <= last_reg[j-1];
                x_reg[j]    <= nx;
                y_reg[j]    <= ny;
            end
        end
    end

    // pixel centre scaling
    assign lvl_tag.valid = v_reg[L];
    assign lvl_tag.last  = last_reg[L];

    hip_scale #(
        .CW (CW),
        .OW (OW)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_tag     (lvl_tag),
        .cell_x     (x_reg[L]),
        .cell_y     (y_reg[L]),
        .total_size (total_size_reg),
        .ord        (eff_ord),
        .out_tag    (sc_tag),
        .out_cell_x (sc_cell_x),
        .out_cell_y (sc_cell_y),
        .pixel_x    (sc_pixel_x),
        .pixel_y    (sc_pixel_y)
    );

    assign push              = adv && sc_tag.valid;
    assign push_data.pixel_y = sc_pixel_y;
    assign push_data.pixel_x = sc_pixel_x;
    assign push_data.cell_y  = sc_cell_y;
    assign push_data.cell_x  = sc_cell_x;
    assign push_data.last    = sc_tag.last;

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.last;
    assign m_tdata  = hip_pkg::TDATA_OUT_W'({out_data_reg.pixel_y, out_data_reg.pixel_x,
                                             out_data_reg.cell_y, out_data_reg.cell_x});

    // skid entry is only filled behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // no result pushed into a full buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        sc_tag.valid && skid_valid_reg |=> $stable(skid_data_reg) && skid_valid_reg
            || $past(m_tready))
        else $error("result overwritten in output buffer");

    // last point of the curve sits on the bottom row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> out_data_reg.cell_y == '0)
        else $error("last curve point not on row zero");

endmodule
